/* sv/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear-probe handle table
// Word formats, command and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int TABLE_BITS = 10;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int COUNT_W    = TABLE_BITS + 1;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
    localparam logic [31:0] KEY_EMPTY = 32'h0000_0000;
    localparam logic [31:0] KEY_TOMB  = 32'h0000_0001;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [15:0] handle_in;
    } req_word_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [15:0]           handle_out;
        logic [TABLE_BITS-1:0] slot;
        logic [COUNT_W-1:0]    entry_count;
    } rsp_word_t;

    // Controller to datapath
    typedef struct packed {
        logic       clear_step;
        logic       capture;
        logic       home;
        logic       advance;
        logic       wr_insert;
        logic       wr_remove;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_handle;
        logic       res_slot;
        logic       load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       key_bad;
        logic       slot_empty;
        logic       slot_tomb;
        logic       slot_match;
        logic       probe_last;
        logic       clear_last;
        logic       out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

/* sv/lpht_dpath.sv */
// ----------------------------------------------------------------------------
// lpht_dpath: datapath of the linear-probe handle table
// Hash unit, probe index, key/handle memories, entry count, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_dpath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lpht_pkg::req_word_t   req,
    input  wire logic                  rsp_stall,
    input  wire lpht_pkg::ctrl_cmd_t   cmd,
    output lpht_pkg::dp_status_t       status,
    output logic                       rsp_valid,
    output lpht_pkg::rsp_word_t        rsp
);

    localparam int TB = lpht_pkg::TABLE_BITS;
    localparam int CW = lpht_pkg::COUNT_W;

    logic [31:0]          key_mem    [lpht_pkg::TABLE_SIZE];
    logic [15:0]          handle_mem [lpht_pkg::TABLE_SIZE];

    lpht_pkg::req_word_t  op_reg;
    logic [31:0]          hash_reg;
    logic [31:0]          hash_next;
    logic [TB-1:0]        idx_reg;
    logic [TB-1:0]        cnt_reg;
    logic [TB-1:0]        clr_reg;
    logic [31:0]          rd_key_reg;
    logic [15:0]          rd_handle_reg;
    logic [1:0]           res_status_reg;
    logic [15:0]          res_handle_reg;
    logic [TB-1:0]        res_slot_reg;
    logic [CW-1:0]        live_reg;
    logic                 out_valid_reg;
    lpht_pkg::rsp_word_t  out_reg;

    logic                 mem_we;
    logic [TB-1:0]        mem_addr;
    logic [31:0]          mem_key;
    logic [15:0]          mem_handle;
    logic [31:0]          fold;

    // Fold the key and scramble with the golden-ratio multiplier
    assign fold      = req.key ^ {16'h0000, req.key[31:16]};
    assign hash_next = fold * lpht_pkg::HASH_MULT;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req;
            hash_reg <= hash_next;
        end
        if (cmd.home)
        begin
            idx_reg <= hash_reg[31 -: TB];
            cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + 1'b1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_handle_reg <= cmd.res_handle ? rd_handle_reg : 16'h0000;
            res_slot_reg   <= cmd.res_slot ? idx_reg : '0;
        end
        if (cmd.load_out)
        begin
            out_reg.status      <= res_status_reg;
            out_reg.handle_out  <= res_handle_reg;
            out_reg.slot        <= res_slot_reg;
            out_reg.entry_count <= live_reg;
        end
    end

    // Single write port: clearing sweep, insert or tombstone
    assign mem_we     = cmd.clear_step | cmd.wr_insert | cmd.wr_remove;
    assign mem_addr   = cmd.clear_step ? clr_reg : idx_reg;
    assign mem_key    = cmd.wr_insert ? op_reg.key
                      : (cmd.wr_remove ? lpht_pkg::KEY_TOMB : lpht_pkg::KEY_EMPTY);
    assign mem_handle = cmd.wr_insert ? op_reg.handle_in : 16'h0000;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_addr] <= mem_key;
        end
        if (cmd.wr_insert | cmd.wr_remove)
        begin
            handle_mem[idx_reg] <= mem_handle;
        end
        rd_key_reg    <= key_mem[idx_reg];
        rd_handle_reg <= handle_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.wr_insert)
            begin
                live_reg <= live_reg + 1'b1;
            end
            else if (cmd.wr_remove && (live_reg != '0))
            begin
                live_reg <= live_reg - 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.cmd        = op_reg.cmd;
        status.key_bad    = (op_reg.key == lpht_pkg::KEY_EMPTY) ||
                            (op_reg.key == lpht_pkg::KEY_TOMB);
        status.slot_empty = (rd_key_reg == lpht_pkg::KEY_EMPTY);
        status.slot_tomb  = (rd_key_reg == lpht_pkg::KEY_TOMB);
        status.slot_match = (rd_key_reg == op_reg.key);
        status.probe_last = (cnt_reg == {TB{1'b1}});
        status.clear_last = (clr_reg == {TB{1'b1}});
        status.out_busy   = out_valid_reg && rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

/* sv/lpht_ctrl.sv */
// ----------------------------------------------------------------------------
// lpht_ctrl: controller of the linear-probe handle table
// Sequences the clearing sweep, home slot, probe loop and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire lpht_pkg::dp_status_t  status,
    output lpht_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HOME  = 6'b000100,
        S_PROBE = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_insert;
    logic   is_remove;

    assign is_insert = (status.cmd == lpht_pkg::CMD_INSERT);
    assign is_remove = (status.cmd == lpht_pkg::CMD_REMOVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                // Unused command first, then reserved keys
                if (!(status.cmd inside {lpht_pkg::CMD_LOOKUP, lpht_pkg::CMD_INSERT,
                                         lpht_pkg::CMD_REMOVE}))
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = lpht_pkg::ST_MISS;
                    state_next     = S_DONE;
                end
                else if (status.key_bad)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = lpht_pkg::ST_INVALID;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.home   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.res_slot = 1'b1;
                if (is_insert && (status.slot_empty || status.slot_tomb))
                begin
                    cmd.wr_insert  = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = lpht_pkg::ST_OK;
                    state_next     = S_DONE;
                end
                else if (!is_insert && status.slot_empty)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = lpht_pkg::ST_MISS;
                    state_next     = S_DONE;
                end
                else if (!is_insert && status.slot_match)
                begin
                    cmd.wr_remove  = is_remove;
                    cmd.res_handle = !is_remove;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = lpht_pkg::ST_OK;
                    state_next     = S_DONE;
                end
                else if (status.probe_last)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = is_insert ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISS;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_PROBE;
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/linear_probe_handle_table.sv */
// Flow: an item is accepted in IDLE; HOME resolves the home slot, then each probe
//   passes PROBE (registered read) and CHECK (compare); DONE loads the result word
//   once the output is free. An invalid key or unused command goes from HOME to
//   DONE. Up to 1024 probes bound a full lap. One item at a time; the single
//   key/handle memory port with its registered read sets the probe step.
// Reset: a clearing sweep writes every key slot empty, with req_stall high.
// ----------------------------------------------------------------------------
// linear_probe_handle_table: window-key to handle hash table
// Open addressing, multiplicative hash, linear probing with tombstones.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_handle_table (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire lpht_pkg::req_word_t  req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output lpht_pkg::rsp_word_t       rsp
);

    // Command and status bundles between the controller and the datapath
    lpht_pkg::ctrl_cmd_t  ctrl_cmd;
    lpht_pkg::dp_status_t dp_status;

    // Controller: clearing sweep after reset, then accept a word, resolve the
    // home slot, walk the probe loop and hand the result to the output register.
    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    // Datapath: hash multiply registered at accept, probe index and counter,
    // key/handle memories with registered read, live entry count, and the
    // output register that holds a finished word while the next one is taken.
    lpht_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (ctrl_cmd),
        .status    (dp_status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // One item in flight: an accepted word holds off the next in the cycle after it
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while previous still in flight");

    // Never overwrite a result word that is still stalled at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_out |-> !(rsp_valid && rsp_stall))
        else $error("result word overwritten before it was taken");

    // Only a successful operation may carry a nonzero handle
    a_handle_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != lpht_pkg::ST_OK)) |-> (rsp.handle_out == 16'h0000))
        else $error("nonzero handle on a failed operation");

    // Invalid keys report slot zero
    a_invalid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == lpht_pkg::ST_INVALID)) |-> (rsp.slot == '0))
        else $error("invalid key reported a nonzero slot");

endmodule

`default_nettype wire

/* tb/sv/lpht_table_checker.sv */
// ----------------------------------------------------------------------------
// lpht_table_checker: result checker for the linear-probe handle table
// Mirrors the key and handle stores, predicts each result word and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_table_checker
    import lpht_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire logic      req_stall,
    input  wire req_word_t req,
    input  wire logic      rsp_valid,
    input  wire logic      rsp_stall,
    input  wire rsp_word_t rsp,
    output int             fail_count,
    output int             open_count,
    output int             ok_seen,
    output int             miss_seen,
    output int             full_seen,
    output int             invalid_seen,
    output int             peak_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        req_word_t asked;
        rsp_word_t want;
    } reply_due_t;

    logic [31:0]        shadow_keys    [TABLE_SIZE];
    logic [15:0]        shadow_handles [TABLE_SIZE];
    logic [COUNT_W-1:0] shadow_live;
    reply_due_t         replies_due [$];

    function automatic logic [TABLE_BITS-1:0] home_of(input logic [31:0] k);
        logic [31:0] folded;
        logic [31:0] prod;
        folded = k ^ (k >> 16);
        prod   = folded * HASH_MULT;
        return prod[31 -: TABLE_BITS];
    endfunction

    // Apply one request to the shadow stores and return the word it should produce.
    function automatic rsp_word_t apply_table_op(input req_word_t w);
        rsp_word_t             r;
        logic [TABLE_BITS-1:0] s;
        logic [31:0]           k;
        int                    n;
        r = '0;
        if (w.cmd != CMD_LOOKUP && w.cmd != CMD_INSERT && w.cmd != CMD_REMOVE) begin
            r.status      = ST_MISS;
            r.entry_count = shadow_live;
            return r;
        end
        if (w.key == KEY_EMPTY || w.key == KEY_TOMB) begin
            r.status      = ST_INVALID;
            r.entry_count = shadow_live;
            return r;
        end
        s = home_of(w.key);
        for (n = 0; n < TABLE_SIZE; n++) begin
            k = shadow_keys[s];
            if (w.cmd == CMD_INSERT) begin
                if (k == KEY_EMPTY || k == KEY_TOMB) begin
                    shadow_keys[s]    = w.key;
                    shadow_handles[s] = w.handle_in;
                    shadow_live       = shadow_live + 1'b1;
                    r.status          = ST_OK;
                    r.slot            = s;
                    r.entry_count     = shadow_live;
                    return r;
                end
            end else if (k == KEY_EMPTY) begin
                r.status      = ST_MISS;
                r.slot        = s;
                r.entry_count = shadow_live;
                return r;
            end else if (k == w.key) begin
                r.status = ST_OK;
                r.slot   = s;
                if (w.cmd == CMD_LOOKUP) begin
                    r.handle_out = shadow_handles[s];
                end else begin
                    shadow_keys[s]    = KEY_TOMB;
                    shadow_handles[s] = '0;
                    if (shadow_live != 0)
                        shadow_live = shadow_live - 1'b1;
                end
                r.entry_count = shadow_live;
                return r;
            end
            // hold the last probed slot once the lap is complete
            if (n + 1 < TABLE_SIZE)
                s = s + 1'b1;
        end
        r.status      = (w.cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
        r.slot        = s;
        r.entry_count = shadow_live;
        return r;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        reply_due_t d;
        if (!rst_n) begin
            for (int j = 0; j < TABLE_SIZE; j++) begin
                shadow_keys[j]    = KEY_EMPTY;
                shadow_handles[j] = '0;
            end
            shadow_live = '0;
            replies_due.delete();
            open_count <= 0;
        end else begin
            // retire first, so a stray word never pairs with a request of this edge
            if (rsp_valid && !rsp_stall) begin
                case (rsp.status)
                    ST_OK:   ok_seen++;
                    ST_MISS: miss_seen++;
                    ST_FULL: full_seen++;
                    default: invalid_seen++;
                endcase
                if (int'(rsp.entry_count) > peak_count)
                    peak_count = int'(rsp.entry_count);
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("result word %h with nothing outstanding", rsp));
                end else begin
                    d = replies_due.pop_front();
                    if (rsp.status !== d.want.status)
                        report_mismatch($sformatf("cmd %0d key %h: status %0d, want %0d",
                            d.asked.cmd, d.asked.key, rsp.status, d.want.status));
                    if (rsp.handle_out !== d.want.handle_out)
                        report_mismatch($sformatf("cmd %0d key %h: handle %h, want %h",
                            d.asked.cmd, d.asked.key, rsp.handle_out, d.want.handle_out));
                    if (rsp.slot !== d.want.slot)
                        report_mismatch($sformatf("cmd %0d key %h: slot %0d, want %0d",
                            d.asked.cmd, d.asked.key, rsp.slot, d.want.slot));
                    if (rsp.entry_count !== d.want.entry_count)
                        report_mismatch($sformatf("cmd %0d key %h: count %0d, want %0d",
                            d.asked.cmd, d.asked.key, rsp.entry_count, d.want.entry_count));
                end
            end
            if (req_valid && !req_stall) begin
                d.asked = req;
                d.want  = apply_table_op(req);
                replies_due.push_back(d);
            end
            open_count <= replies_due.size();
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the linear-probe handle table
// Drives directed and random lookup/insert/remove words through the table,
// fills it to the brink and past it, then drains it; a checker module beside
// the block predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int          CLK_PERIOD = 10;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          POOL_SIZE  = 40;
    localparam int          MIXED_WORDS = 350;
    localparam int          FILL_WORDS  = 1150;
    localparam int          DRAIN_WORDS = 150;
    // Slowest case: every word runs a full lap of probes, plus the longest sender
    // gap and receiver stall, times three, plus the clearing sweep.
    localparam int unsigned LIMIT_CYCLES = 12_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    int fail_count, open_count, ok_seen, miss_seen, full_seen, invalid_seen, peak_count;

    int          words_sent;
    int          burst_left;
    int          stall_run;
    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] filled_keys [$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    linear_probe_handle_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lpht_table_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .open_count   (open_count),
        .ok_seen      (ok_seen),
        .miss_seen    (miss_seen),
        .full_seen    (full_seen),
        .invalid_seen (invalid_seen),
        .peak_count   (peak_count)
    );

    // Receiver back-pressure: alternate open windows and stalls. A few stalls are
    // long, and some open windows run for a long stretch so results also drain
    // with no back-pressure at all.
    always @(posedge clk) begin
        if (rst_n) begin
            if (stall_run > 0) begin
                stall_run--;
            end else if (rsp_stall) begin
                rsp_stall <= 1'b0;
                stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(0, 12);
            end else begin
                rsp_stall <= 1'b1;
                stall_run = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                         : $urandom_range(0, 3);
            end
        end
    end

    // Idle cycles before the next request word: mostly none or short, a few
    // long, and now and then a burst of back-to-back words.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r <= 2)
            return $urandom_range(8, 30);
        if (r <= 10)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    function automatic req_word_t make_word(input logic [1:0] c, input logic [31:0] k,
                                            input logic [15:0] h);
        req_word_t w;
        w.cmd       = c;
        w.key       = k;
        w.handle_in = h;
        return w;
    endfunction

    function automatic logic [31:0] pool_key();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [31:0] filled_key();
        return filled_keys[$urandom_range(0, filled_keys.size() - 1)];
    endfunction

    // Present one request word and hold it until the block takes it. Called at a
    // rising edge; returns at the edge where the word was accepted, with valid
    // still high so a following word goes out without a bubble.
    task automatic send_word(input req_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        words_sent++;
    endtask

    // Give up if the run hangs anywhere.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still outstanding", cycles, open_count);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int          directed_words;
        int          pick;
        logic [1:0]  c;
        logic [31:0] k;

        for (int j = 0; j < POOL_SIZE; j++)
            key_pool[j] = $urandom | 32'h2;    // keep pool keys out of the reserved pair

        // Hold reset, then release it at an edge; the block sweeps its key store
        // clean afterwards and stalls requests until it is done.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, reserved keys, unused command, extremes of key
        // and handle, duplicates, tombstones passed over and reused.
        send_word(make_word(CMD_LOOKUP, 32'h0000_0002, 16'h0000));   // miss on empty slot
        send_word(make_word(CMD_INSERT, KEY_EMPTY,     16'hFFFF));   // invalid key
        send_word(make_word(CMD_INSERT, KEY_TOMB,      16'hFFFF));
        send_word(make_word(CMD_LOOKUP, KEY_EMPTY,     16'h0000));
        send_word(make_word(CMD_REMOVE, KEY_TOMB,      16'h0000));
        send_word(make_word(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF));   // unused command
        send_word(make_word(CMD_UNUSED, KEY_EMPTY,     16'h0000));
        send_word(make_word(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF));
        send_word(make_word(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000));   // hit, all-ones handle
        send_word(make_word(CMD_INSERT, 32'h0000_0002, 16'h0000));
        send_word(make_word(CMD_INSERT, 32'hFFFF_FFFF, 16'h1234));   // duplicate key
        send_word(make_word(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000));   // finds the first copy
        send_word(make_word(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF));   // leaves a tombstone
        send_word(make_word(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000));   // passes it, hits the copy
        send_word(make_word(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000));
        send_word(make_word(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000));   // miss past two tombstones
        send_word(make_word(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000));   // remove miss
        send_word(make_word(CMD_INSERT, 32'hFFFF_FFFF, 16'h5555));   // reuses a tombstone
        send_word(make_word(CMD_LOOKUP, 32'h0000_0002, 16'hFFFF));   // hit, zero handle
        send_word(make_word(CMD_INSERT, 32'h0001_0001, 16'hAAAA));   // low half folds to zero
        send_word(make_word(CMD_LOOKUP, 32'h0001_0001, 16'h0000));
        send_word(make_word(CMD_INSERT, 32'h8000_0000, 16'h8001));
        send_word(make_word(CMD_REMOVE, 32'hDEAD_BEEF, 16'h0000));
        directed_words = words_sent;

        // Mixed traffic on a small key pool so hits, removes and tombstones pile up.
        for (int i = 0; i < MIXED_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                c = CMD_LOOKUP;
            else if (pick < 70)
                c = CMD_INSERT;
            else if (pick < 96)
                c = CMD_REMOVE;
            else
                c = CMD_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                k = $urandom_range(0, 1);
            else if (pick < 80)
                k = pool_key();
            else
                k = $urandom;
            send_word(make_word(c, k, 16'($urandom_range(0, 16'hFFFF))));
        end

        // Fill: insert fresh keys until the table is full and then some, so
        // long clusters wrap the end of the table and inserts report full.
        for (int i = 0; i < FILL_WORDS; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                k = ($urandom_range(0, 1) == 0) ? pool_key() : $urandom;
                send_word(make_word(CMD_LOOKUP, k, 16'($urandom_range(0, 16'hFFFF))));
            end else begin
                k = $urandom;
                filled_keys.push_back(k);
                send_word(make_word(CMD_INSERT, k, 16'($urandom_range(0, 16'hFFFF))));
            end
        end

        // Drain: remove and look up filled keys; misses on a table with no
        // empty slot run a full lap.
        for (int i = 0; i < DRAIN_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_word(make_word(CMD_REMOVE, filled_key(),
                                    16'($urandom_range(0, 16'hFFFF))));
            else if (pick < 80)
                send_word(make_word(CMD_LOOKUP, filled_key(),
                                    16'($urandom_range(0, 16'hFFFF))));
            else if (pick < 90)
                send_word(make_word(CMD_LOOKUP, $urandom,
                                    16'($urandom_range(0, 16'hFFFF))));
            else
                send_word(make_word(CMD_INSERT, $urandom,
                                    16'($urandom_range(0, 16'hFFFF))));
        end
        req_valid <= 1'b0;

        // Let the checker see the last accept, wait out every result, then idle
        // a little to catch any stray word.
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d request words (%0d directed, %0d random), peak entry count %0d",
                 words_sent, directed_words, words_sent - directed_words, peak_count);
        $display("results: %0d done/hit, %0d miss, %0d table full, %0d invalid; %0d mismatches",
                 ok_seen, miss_seen, full_seen, invalid_seen, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
